[design/btpt_pkg.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix table: shared package
// Field widths, operation codes, beat types and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package btpt_pkg;

	// Fixed field widths of the input and result beats.
	localparam int ADDR_BITS = 32;
	localparam int ID_BITS   = 8;
	localparam int LEN_W     = 6;
	localparam int FUNC_W    = 2;

	// Default size of the node store.
	localparam int NODES_DEFAULT = 1024;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	// Status codes.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// One input beat.
	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [ADDR_BITS-1:0] prefix_bits;
		logic [LEN_W-1:0]     prefix_len;
		logic [ID_BITS-1:0]   route_id;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic               found;
		logic [ID_BITS-1:0] next_hop;
		logic [LEN_W-1:0]   walk_depth;
		logic               status;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic finish;
	} dp_status_t;

endpackage

`default_nettype wire

[design/binary_trie_prefix_table.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix table
// Longest prefix match table kept as a binary trie in a node store.
// ----------------------------------------------------------------------------
// Usage:
//   An operation beat (item) is taken at a clock edge where start is high and
//   busy is low. func selects add route, lookup address or remove route.
//   Exactly one result beat follows on result, marked by done for a single
//   cycle; the receiver cannot stall it, so it must take it in that cycle.
//   The beat is loaded, the trie is walked level by level until a final walk
//   step ends the walk, then the result beat is shown. A lookup walks at most
//   ADDR_BITS levels; add and remove walk at most prefix_len levels. One operation is
//   in flight at a time; start is ignored while busy is high.
//   The pace is set by the node RAM: each level needs the record of the
//   current node, read through the single registered RAM read port.
//   Reset clears the root node and restarts allocation at node one; nodes
//   other than the root are written when allocated and need no clearing.
//   Nodes are never freed; an add that runs out of nodes reports status 1.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_prefix_table #(
	parameter int NODES = btpt_pkg::NODES_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire btpt_pkg::in_item_t  item,
	output logic                     busy,
	output logic                     done,
	output btpt_pkg::out_item_t      result
);

	btpt_pkg::ctl_cmd_t   cmd;
	btpt_pkg::dp_status_t dp_status;

	btpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dp_status (dp_status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	btpt_datapath #(
		.NODES (NODES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.dp_status (dp_status),
		.result    (result)
	);

endmodule

`default_nettype wire

[design/btpt_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module btpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/btpt_ctrl.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix table: controller
// Sequences one operation: load, walk one trie level per cycle, then show the
// result beat for a single cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btpt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire btpt_pkg::dp_status_t  dp_status,
	output btpt_pkg::ctl_cmd_t         cmd,
	output logic                       busy,
	output logic                       done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_WALK;
				end
			end
			ST_WALK: begin
				if (dp_status.finish) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Commands and handshake outputs.
	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.step = (state_q == ST_WALK);
		busy     = (state_q != ST_IDLE);
		done     = (state_q == ST_DONE);
	end

endmodule

`default_nettype wire

[design/btpt_datapath.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix table: datapath
// Holds the root node in flip-flops and all other nodes in a RAM, walks one
// trie level per step, allocates nodes on add and builds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module btpt_datapath #(
	parameter int NODES = btpt_pkg::NODES_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire btpt_pkg::ctl_cmd_t   cmd,
	input  wire btpt_pkg::in_item_t   item,
	output btpt_pkg::dp_status_t      dp_status,
	output btpt_pkg::out_item_t       result
);

	localparam int IDX_W = $clog2(NODES);
	localparam int CNT_W = IDX_W + 1;
	localparam int LEN_W = btpt_pkg::LEN_W;
	localparam int ID_W  = btpt_pkg::ID_BITS;
	localparam int ADR_W = btpt_pkg::ADDR_BITS;

	// Where the record of the current node comes from.
	localparam logic [1:0] SRC_ROOT  = 2'd0;
	localparam logic [1:0] SRC_RAM   = 2'd1;
	localparam logic [1:0] SRC_LOCAL = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0] c0;
		logic [IDX_W-1:0] c1;
		logic             valid;
		logic [ID_W-1:0]  id;
	} node_rec_t;

	localparam int REC_W = $bits(node_rec_t);

	// Operation registers.
	logic [btpt_pkg::FUNC_W-1:0] func_q;
	logic [ADR_W-1:0]            bits_q;
	logic [LEN_W-1:0]            len_q;
	logic [ID_W-1:0]             id_q;
	logic [LEN_W-1:0]            depth_q;
	logic [IDX_W-1:0]            cur_q;
	logic [1:0]                  src_q;
	node_rec_t                   local_q;
	logic                        found_q;
	logic [ID_W-1:0]             hop_q;

	// Persistent state.
	node_rec_t                   root_q;
	logic [CNT_W-1:0]            free_q;

	// Result register.
	btpt_pkg::out_item_t         res_q;

	// RAM interface.
	logic [REC_W-1:0]            ram_rdata;
	logic                        ram_we;
	logic                        ram_re;

	// Step decisions.
	node_rec_t                   rec;
	node_rec_t                   wr_rec;
	logic                        bit_cur;
	logic [IDX_W-1:0]            child;
	logic                        child_none;
	logic                        at_len;
	logic                        at_max;
	logic                        full;
	logic                        advance;
	logic                        alloc;
	logic                        wr_en;
	logic                        finish;
	logic                        set_full;
	logic                        hit;
	logic                        found_next;
	logic [ID_W-1:0]             hop_next;
	logic [LEN_W-1:0]            len_sat;

	// Saturate the prefix length to the address width.
	assign len_sat = (item.prefix_len > LEN_W'(ADR_W)) ? LEN_W'(ADR_W) : item.prefix_len;

	// Current node record and the child selected by the next address bit.
	always_comb begin
		case (src_q)
			SRC_ROOT:  rec = root_q;
			SRC_RAM:   rec = node_rec_t'(ram_rdata);
			SRC_LOCAL: rec = local_q;
			default:   rec = local_q;
		endcase
		bit_cur    = bits_q[ADR_W-1];
		child      = bit_cur ? rec.c1 : rec.c0;
		child_none = (child == '0);
		at_len     = (depth_q == len_q);
		at_max     = (depth_q == LEN_W'(ADR_W));
		full       = (free_q == CNT_W'(NODES));
	end

	// Per-level decision for each operation.
	always_comb begin
		advance  = 1'b0;
		alloc    = 1'b0;
		wr_en    = 1'b0;
		wr_rec   = rec;
		finish   = 1'b0;
		set_full = 1'b0;
		hit      = 1'b0;
		case (func_q)
			btpt_pkg::FUNC_ADD: begin
				if (at_len) begin
					wr_en        = 1'b1;
					wr_rec.valid = 1'b1;
					wr_rec.id    = id_q;
					finish       = 1'b1;
				end else if (!child_none) begin
					advance = 1'b1;
				end else if (full) begin
					// Write back unchanged so a freshly linked node gets stored.
					wr_en    = 1'b1;
					finish   = 1'b1;
					set_full = 1'b1;
				end else begin
					alloc = 1'b1;
					wr_en = 1'b1;
					if (bit_cur) begin
						wr_rec.c1 = free_q[IDX_W-1:0];
					end else begin
						wr_rec.c0 = free_q[IDX_W-1:0];
					end
				end
			end
			btpt_pkg::FUNC_FIND: begin
				hit = rec.valid;
				if (at_max || child_none) begin
					finish = 1'b1;
				end else begin
					advance = 1'b1;
				end
			end
			btpt_pkg::FUNC_REMOVE: begin
				if (at_len) begin
					finish = 1'b1;
					if (rec.valid && (rec.id == id_q)) begin
						wr_en        = 1'b1;
						wr_rec.valid = 1'b0;
						wr_rec.id    = '0;
					end
				end else if (child_none) begin
					finish = 1'b1;
				end else begin
					advance = 1'b1;
				end
			end
			default: begin
				finish = 1'b1;
			end
		endcase
		found_next = hit ? 1'b1 : found_q;
		hop_next   = hit ? rec.id : hop_q;
	end

	// The root lives in flip-flops; every other node goes to the RAM.
	assign ram_we = cmd.step && wr_en && (cur_q != '0);
	assign ram_re = cmd.step && advance;

	assign dp_status.finish = cmd.step && finish;

	btpt_ram #(
		.WIDTH (REC_W),
		.DEPTH (NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q),
		.wdata (REC_W'(wr_rec)),
		.re    (ram_re),
		.raddr (child),
		.rdata (ram_rdata)
	);

	// Root node and allocation counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			free_q <= CNT_W'(1);
		end else if (cmd.step) begin
			if (wr_en && (cur_q == '0)) begin
				root_q <= wr_rec;
			end
			if (alloc) begin
				free_q <= free_q + CNT_W'(1);
			end
		end
	end

	// Walk control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SRC_ROOT;
		end else if (cmd.load) begin
			src_q <= SRC_ROOT;
		end else if (cmd.step) begin
			if (advance) begin
				src_q <= SRC_RAM;
			end else if (alloc) begin
				src_q <= SRC_LOCAL;
			end
		end
	end

	// Operation payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= item.func;
			bits_q  <= item.prefix_bits;
			len_q   <= len_sat;
			id_q    <= item.route_id;
			depth_q <= '0;
			cur_q   <= '0;
			found_q <= 1'b0;
			hop_q   <= '0;
		end else if (cmd.step) begin
			found_q <= found_next;
			hop_q   <= hop_next;
			if (advance || alloc) begin
				depth_q <= depth_q + LEN_W'(1);
				bits_q  <= {bits_q[ADR_W-2:0], 1'b0};
			end
			if (advance) begin
				cur_q <= child;
			end else if (alloc) begin
				cur_q   <= free_q[IDX_W-1:0];
				local_q <= '0;
			end
		end
	end

	// Result beat, captured on the final step.
	always_ff @(posedge clk) begin
		if (cmd.step && finish) begin
			res_q.found      <= found_next;
			res_q.next_hop   <= hop_next;
			res_q.walk_depth <= depth_q;
			res_q.status     <= set_full ? btpt_pkg::STATUS_FULL : btpt_pkg::STATUS_OK;
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

[design/btpt_checker.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix table: port checker
// Watches the top level ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module btpt_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire btpt_pkg::out_item_t result
);

	// An accepted beat makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// The result beat is shown while busy and lasts a single cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 (!done && !busy))
		else $error("result beat not a single cycle ending the operation");

	// No hop is reported without a match.
	a_hop_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.next_hop == '0))
		else $error("next hop without a match");

	// A store-full add never reports a match.
	a_full_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> !result.found)
		else $error("store full reported together with a match");

endmodule

bind binary_trie_prefix_table btpt_checker u_checker (.*);

`default_nettype wire
